// ===== sv/cqo_pkg.sv =====
`default_nettype none

package cqo_pkg;

  localparam int RADIUS_WIDTH    = 20;
  localparam int NUM_CORNERS     = 4;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int M_TDATA_WIDTH   = 8;
  localparam int NUM_STAGES      = 8;

  // configuration register map
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CORNER0_X = 3'd0,
    CORNER0_Y = 3'd1,
    CORNER1_X = 3'd2,
    CORNER1_Y = 3'd3,
    CORNER2_X = 3'd4,
    CORNER2_Y = 3'd5,
    CORNER3_X = 3'd6,
    CORNER3_Y = 3'd7
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== sv/circle_quad_overlap_test.sv =====
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tdata: center_x, center_y, radius
// m_*       out  m_tvalid/m_tready    m_tdata: hit
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data (one corner coordinate)
//
// Eight register stages lie between a beat accepted on s_* and its result on m_*.
// One beat enters per cycle when not stalled; the wide squared compare of the
// edge test is split into half-width partial products over stages five to eight.
// Each stage holds only while it is full and the stage after it holds, so a
// stall fills the bubbles ahead of it and loses nothing.
// rst clears the stage valid bits and all corners to zero; cfg_ready is always high.
`default_nettype none

module circle_quad_overlap_test #(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  // s_tdata fields, low bit up: center_x, center_y, radius, zero pad
  input  wire logic [((2*COORD_WIDTH+cqo_pkg::RADIUS_WIDTH+7)/8)*8-1:0] s_tdata,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // m_tdata fields, low bit up: hit, zero pad
  output logic [cqo_pkg::M_TDATA_WIDTH-1:0] m_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [cqo_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [COORD_WIDTH-1:0] cfg_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int RW   = cqo_pkg::RADIUS_WIDTH;
  localparam int NC   = cqo_pkg::NUM_CORNERS;
  localparam int NS   = cqo_pkg::NUM_STAGES;
  localparam int DW   = CW + 1;             // coordinate difference
  localparam int PW   = 2 * DW;             // products and their sums, signed
  localparam int CMW  = PW - 1;             // magnitudes of cross, dist, len
  localparam int H    = (CMW + 1) / 2;      // split point of magnitudes
  localparam int CSW  = 2 * CMW;            // cross squared
  localparam int RLW  = RW + CMW;           // radius times len
  localparam int G    = (RLW + 1) / 2;      // split point of radius times len
  localparam int RRW  = RW + RLW;           // radius squared times len
  localparam int CPW  = (CSW > RRW) ? CSW : RRW;
  localparam int DCW  = (CMW > 2 * RW) ? CMW : 2 * RW;

  // configuration
  logic signed [CW-1:0] corner_x [NC];
  logic signed [CW-1:0] corner_y [NC];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NC; i++) begin
        corner_x[i] <= '0;
        corner_y[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (cqo_pkg::cfg_reg_t'(cfg_index))
        cqo_pkg::CORNER0_X: corner_x[0] <= cfg_data;
        cqo_pkg::CORNER0_Y: corner_y[0] <= cfg_data;
        cqo_pkg::CORNER1_X: corner_x[1] <= cfg_data;
        cqo_pkg::CORNER1_Y: corner_y[1] <= cfg_data;
        cqo_pkg::CORNER2_X: corner_x[2] <= cfg_data;
        cqo_pkg::CORNER2_Y: corner_y[2] <= cfg_data;
        cqo_pkg::CORNER3_X: corner_x[3] <= cfg_data;
        cqo_pkg::CORNER3_Y: corner_y[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage advance
  logic [NS-1:0] v;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v[NS-1] || m_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= s_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // input unpack
  logic [CW-1:0] center_x;
  logic [CW-1:0] center_y;
  logic [RW-1:0] radius;

  assign center_x = s_tdata[CW-1:0];
  assign center_y = s_tdata[2*CW-1:CW];
  assign radius   = s_tdata[2*CW+RW-1:2*CW];

  // stage 1: differences to each corner and edge vectors
  logic signed [DW-1:0] wx1 [NC];
  logic signed [DW-1:0] wy1 [NC];
  logic signed [DW-1:0] dx1 [NC];
  logic signed [DW-1:0] dy1 [NC];
  logic [RW-1:0] r1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r1 <= radius;
      for (int i = 0; i < NC; i++) begin
        wx1[i] <= {center_x[CW-1], center_x} - {corner_x[i][CW-1], corner_x[i]};
        wy1[i] <= {center_y[CW-1], center_y} - {corner_y[i][CW-1], corner_y[i]};
        dx1[i] <= {corner_x[(i+1)%NC][CW-1], corner_x[(i+1)%NC]}
                  - {corner_x[i][CW-1], corner_x[i]};
        dy1[i] <= {corner_y[(i+1)%NC][CW-1], corner_y[(i+1)%NC]}
                  - {corner_y[i][CW-1], corner_y[i]};
      end
    end
  end

  // stage 2: products
  logic signed [PW-1:0] sqx2 [NC];
  logic signed [PW-1:0] sqy2 [NC];
  logic signed [PW-1:0] nx2  [NC];
  logic signed [PW-1:0] ny2  [NC];
  logic signed [PW-1:0] lx2  [NC];
  logic signed [PW-1:0] ly2  [NC];
  logic signed [PW-1:0] kx2  [NC];
  logic signed [PW-1:0] ky2  [NC];
  logic [2*RW-1:0] rr2;
  logic [RW-1:0]   r2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rr2 <= r1 * r1;
      r2  <= r1;
      for (int i = 0; i < NC; i++) begin
        sqx2[i] <= wx1[i] * wx1[i];
        sqy2[i] <= wy1[i] * wy1[i];
        nx2[i]  <= dx1[i] * wx1[i];
        ny2[i]  <= dy1[i] * wy1[i];
        lx2[i]  <= dx1[i] * dx1[i];
        ly2[i]  <= dy1[i] * dy1[i];
        kx2[i]  <= dx1[i] * wy1[i];
        ky2[i]  <= dy1[i] * wx1[i];
      end
    end
  end

  // stage 3: corner distance, projection, edge length, cross
  logic signed [PW-1:0] dist3 [NC];
  logic signed [PW-1:0] n3    [NC];
  logic signed [PW-1:0] len3  [NC];
  logic signed [PW-1:0] cr3   [NC];
  logic [2*RW-1:0] rr3;
  logic [RW-1:0]   r3;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rr3 <= rr2;
      r3  <= r2;
      for (int i = 0; i < NC; i++) begin
        dist3[i] <= sqx2[i] + sqy2[i];
        n3[i]    <= nx2[i] + ny2[i];
        len3[i]  <= lx2[i] + ly2[i];
        cr3[i]   <= kx2[i] - ky2[i];
      end
    end
  end

  // stage 4: corner and interior decisions, edge range check, cross magnitude
  logic            corner_hit;
  logic            inside_hit;
  logic [NC-1:0]   eok_next;
  logic [PW-1:0]   cr_neg [NC];
  logic [CMW-1:0]  c_next [NC];

  always_comb begin
    corner_hit = 1'b0;
    for (int i = 0; i < NC; i++) begin
      if (DCW'(dist3[i][CMW-1:0]) < DCW'(rr3)) corner_hit = 1'b1;
      eok_next[i] = (len3[i] != '0) && (n3[i] > 0) && (n3[i] < len3[i]);
      cr_neg[i]   = -cr3[i];
      c_next[i]   = cr3[i][PW-1] ? cr_neg[i][CMW-1:0] : cr3[i][CMW-1:0];
    end
    // at corners 0 and 2 the centre is on the inner side of the edge, not behind it
    inside_hit = !cr3[0][PW-1] && !n3[0][PW-1] && !cr3[2][PW-1] && !n3[2][PW-1];
  end

  logic            hit4;
  logic [NC-1:0]   eok4;
  logic [CMW-1:0]  c4   [NC];
  logic [CMW-1:0]  len4 [NC];
  logic [RW-1:0]   r4;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      hit4 <= corner_hit || inside_hit;
      eok4 <= eok_next;
      r4   <= r3;
      for (int i = 0; i < NC; i++) begin
        c4[i]   <= c_next[i];
        len4[i] <= len3[i][CMW-1:0];
      end
    end
  end

  // stage 5: half-width partial products of cross^2 and radius*len
  logic [2*(CMW-H)-1:0] phh5 [NC];
  logic [CMW-1:0]       phl5 [NC];
  logic [2*H-1:0]       pll5 [NC];
  logic [RW+CMW-H-1:0]  prh5 [NC];
  logic [RW+H-1:0]      prl5 [NC];
  logic                 hit5;
  logic [NC-1:0]        eok5;
  logic [RW-1:0]        r5;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      hit5 <= hit4;
      eok5 <= eok4;
      r5   <= r4;
      for (int i = 0; i < NC; i++) begin
        phh5[i] <= c4[i][CMW-1:H] * c4[i][CMW-1:H];
        phl5[i] <= c4[i][CMW-1:H] * c4[i][H-1:0];
        pll5[i] <= c4[i][H-1:0] * c4[i][H-1:0];
        prh5[i] <= r4 * len4[i][CMW-1:H];
        prl5[i] <= r4 * len4[i][H-1:0];
      end
    end
  end

  // stage 6: assemble cross^2 and radius*len
  logic [CSW-1:0] csq6 [NC];
  logic [RLW-1:0] rl6  [NC];
  logic           hit6;
  logic [NC-1:0]  eok6;
  logic [RW-1:0]  r6;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      hit6 <= hit5;
      eok6 <= eok5;
      r6   <= r5;
      for (int i = 0; i < NC; i++) begin
        csq6[i] <= {phh5[i], pll5[i]} + (CSW'(phl5[i]) << (H + 1));
        rl6[i]  <= (RLW'(prh5[i]) << H) + RLW'(prl5[i]);
      end
    end
  end

  // stage 7: radius times radius*len, in halves
  logic [RW+RLW-G-1:0] prrh7 [NC];
  logic [RW+G-1:0]     prrl7 [NC];
  logic [CSW-1:0]      csq7  [NC];
  logic                hit7;
  logic [NC-1:0]       eok7;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      hit7 <= hit6;
      eok7 <= eok6;
      for (int i = 0; i < NC; i++) begin
        csq7[i]  <= csq6[i];
        prrh7[i] <= r6 * rl6[i][RLW-1:G];
        prrl7[i] <= r6 * rl6[i][G-1:0];
      end
    end
  end

  // stage 8: edge distance compare, output register
  logic [RRW-1:0] rrl [NC];
  logic           edge_hit;
  logic           hit8;

  always_comb begin
    edge_hit = 1'b0;
    for (int i = 0; i < NC; i++) begin
      rrl[i] = (RRW'(prrh7[i]) << G) + RRW'(prrl7[i]);
      if (eok7[i] && (CPW'(csq7[i]) < CPW'(rrl[i]))) edge_hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      hit8 <= hit7 || edge_hit;
    end
  end

  assign m_tdata = {{(cqo_pkg::M_TDATA_WIDTH-1){1'b0}}, hit8};

  // a result appears only when the stage before the output was full
  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(v[NS-2]))
    else $error("result appeared with empty stage seven");

  // a held middle stage keeps its beat
  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (v[3] && !en[3]) |=> v[3])
    else $error("stage four dropped a held beat");

  // input ready only when some stage can take a beat
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (m_tready || !(&v)))
    else $error("input ready with a full, stalled pipeline");

endmodule

`default_nettype wire

// ===== test/overlap_checker.sv =====
`timescale 1ns / 100ps

module overlap_checker #(
  parameter int COORD_W = 24,
  parameter int S_W     = 72
) (
  input  wire logic clk,
  input  wire logic rst,
  // s_tdata fields, low bit up: center_x, center_y, radius, zero pad
  input  wire logic [S_W-1:0] s_tdata,
  input  wire logic s_tvalid,
  input  wire logic s_tready,
  // m_tdata fields, low bit up: hit, zero pad
  input  wire logic [cqo_pkg::M_TDATA_WIDTH-1:0] m_tdata,
  input  wire logic m_tvalid,
  input  wire logic m_tready,
  input  wire logic cfg_valid,
  input  wire logic cfg_ready,
  input  wire logic [cqo_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [COORD_W-1:0] cfg_data,
  output int        errors,
  output int        pending,
  output int        results_seen,
  output int        hits_seen
);

  longint corner_x[cqo_pkg::NUM_CORNERS];
  longint corner_y[cqo_pkg::NUM_CORNERS];
  logic   expected_hits[$];

  // Exact overlap decision on sign-extended coordinates; squared compares only.
  function automatic logic overlap_hit(input longint px, input longint py, input longint rad);
    longint dx, dy, wx, wy, dot_n, len, cr, cmag, r2, ax, ay, ex, ey;
    logic [127:0] lhs, rhs;
    logic hit;
    int j;
    hit = 1'b0;
    r2 = rad * rad;
    // corner strictly inside the circle
    for (int i = 0; i < cqo_pkg::NUM_CORNERS; i++) begin
      dx = px - corner_x[i];
      dy = py - corner_y[i];
      if (dx * dx + dy * dy < r2) hit = 1'b1;
    end
    // centre inside: sign tests at corners 0 and 2, zero counts as inside
    ax = corner_x[1] - corner_x[0];
    ay = corner_y[1] - corner_y[0];
    ex = corner_x[3] - corner_x[2];
    ey = corner_y[3] - corner_y[2];
    if (ax * (py - corner_y[0]) - ay * (px - corner_x[0]) >= 0 &&
        ax * (px - corner_x[0]) + ay * (py - corner_y[0]) >= 0 &&
        ex * (py - corner_y[2]) - ey * (px - corner_x[2]) >= 0 &&
        ex * (px - corner_x[2]) + ey * (py - corner_y[2]) >= 0) hit = 1'b1;
    // centre near an edge, only where the projection falls strictly inside it
    for (int i = 0; i < cqo_pkg::NUM_CORNERS; i++) begin
      j = (i + 1) % cqo_pkg::NUM_CORNERS;
      dx = corner_x[j] - corner_x[i];
      dy = corner_y[j] - corner_y[i];
      wx = px - corner_x[i];
      wy = py - corner_y[i];
      dot_n = dx * wx + dy * wy;
      len = dx * dx + dy * dy;
      if (len != 0 && dot_n > 0 && dot_n < len) begin
        cr = dx * wy - dy * wx;
        cmag = (cr < 0) ? -cr : cr;
        lhs = {64'd0, cmag};
        lhs = lhs * lhs;
        rhs = {64'd0, r2};
        rhs = rhs * {64'd0, len};
        if (lhs < rhs) hit = 1'b1;
      end
    end
    return hit;
  endfunction

  always @(posedge clk) begin
    longint coord;
    logic want;
    if (rst) begin
      expected_hits.delete();
      for (int i = 0; i < cqo_pkg::NUM_CORNERS; i++) begin
        corner_x[i] = 0;
        corner_y[i] = 0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        coord = longint'($signed(cfg_data));
        case (cqo_pkg::cfg_reg_t'(cfg_index))
          cqo_pkg::CORNER0_X: corner_x[0] = coord;
          cqo_pkg::CORNER0_Y: corner_y[0] = coord;
          cqo_pkg::CORNER1_X: corner_x[1] = coord;
          cqo_pkg::CORNER1_Y: corner_y[1] = coord;
          cqo_pkg::CORNER2_X: corner_x[2] = coord;
          cqo_pkg::CORNER2_Y: corner_y[2] = coord;
          cqo_pkg::CORNER3_X: corner_x[3] = coord;
          cqo_pkg::CORNER3_Y: corner_y[3] = coord;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (m_tdata[0]) hits_seen++;
        if (expected_hits.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, got hit=%0b",
                   $time, m_tdata[0]);
        end else begin
          want = expected_hits.pop_front();
          if (m_tdata[0] !== want) begin
            errors++;
            $display("%0t: hit mismatch, expected %0b, got %0b", $time, want, m_tdata[0]);
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_hits.push_back(overlap_hit(
          longint'($signed(s_tdata[COORD_W-1:0])),
          longint'($signed(s_tdata[2*COORD_W-1:COORD_W])),
          longint'(s_tdata[2*COORD_W +: cqo_pkg::RADIUS_WIDTH])));
    end
    pending = expected_hits.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int COORD_W    = 24;
  localparam int S_W        = ((2*COORD_W + cqo_pkg::RADIUS_WIDTH + 7) / 8) * 8;
  localparam int RADIUS_MAX = (1 << cqo_pkg::RADIUS_WIDTH) - 1;
  localparam longint C_MIN  = -(longint'(1) << (COORD_W - 1));
  localparam longint C_MAX  = (longint'(1) << (COORD_W - 1)) - 1;

  logic clk;
  logic rst = 1'b1;
  logic [S_W-1:0] s_tdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [cqo_pkg::M_TDATA_WIDTH-1:0] m_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cqo_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_data = '0;

  int errors, pending, results_seen, hits_seen;
  int items_sent = 0;
  int settings_used = 1;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int rx_hold = 0;
  int rx_last = 0;
  longint rect_x[cqo_pkg::NUM_CORNERS] = '{0, 0, 0, 0};
  longint rect_y[cqo_pkg::NUM_CORNERS] = '{0, 0, 0, 0};

  circle_quad_overlap_test #(.COORD_WIDTH(COORD_W)) uut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  overlap_checker #(.COORD_W(COORD_W), .S_W(S_W)) overlap_chk (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending),
    .results_seen(results_seen), .hits_seen(hits_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result side: after each accepted beat, hold tready low for a random stretch.
  always @(negedge clk) begin
    if (results_seen != rx_last) begin
      rx_last = results_seen;
      rx_hold = rx_quiet ? 0 : $urandom_range(0, 15);
    end
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic longint jitter(input int unsigned span);
    return longint'($urandom_range(0, 2 * span)) - longint'(span);
  endfunction

  function automatic longint rand_coord();
    logic [COORD_W-1:0] raw;
    raw = COORD_W'($urandom);
    return longint'($signed(raw));
  endfunction

  task automatic send_circle(input longint x, input longint y, input longint rad);
    int gap;
    logic [COORD_W-1:0] cx, cy;
    logic [cqo_pkg::RADIUS_WIDTH-1:0] r;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    cx = x[COORD_W-1:0];
    cy = y[COORD_W-1:0];
    r = rad[cqo_pkg::RADIUS_WIDTH-1:0];
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= S_W'({r, cy, cx});
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Corners go in counterclockwise order for a proper interior.
  task automatic load_quad(input longint x0, input longint y0, input longint x1,
                           input longint y1, input longint x2, input longint y2,
                           input longint x3, input longint y3);
    wait_drain();
    rect_x = '{x0, x1, x2, x3};
    rect_y = '{y0, y1, y2, y3};
    for (int k = 0; k < 2 * cqo_pkg::NUM_CORNERS; k++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= cqo_pkg::cfg_reg_t'(k);
      cfg_data <= (k % 2 == 0) ? rect_x[k / 2][COORD_W-1:0] : rect_y[k / 2][COORD_W-1:0];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_circle();
    longint x, y, rad;
    int unsigned span;
    int c, nxt, t;
    c = $urandom_range(0, cqo_pkg::NUM_CORNERS - 1);
    nxt = (c + 1) % cqo_pkg::NUM_CORNERS;
    span = 1 << $urandom_range(0, 22);
    rad = longint'((span > RADIUS_MAX) ? $urandom_range(0, RADIUS_MAX)
                                       : $urandom_range(0, span));
    case ($urandom_range(0, 9))
      0, 1: begin
        x = longint'($urandom);
        y = longint'($urandom);
        rad = longint'($urandom);
      end
      2, 3, 4: begin
        x = rect_x[c] + jitter(span);
        y = rect_y[c] + jitter(span);
      end
      5, 6: begin
        x = (rect_x[c] + rect_x[nxt]) / 2 + jitter(span);
        y = (rect_y[c] + rect_y[nxt]) / 2 + jitter(span);
      end
      7: begin
        x = (rect_x[0] + rect_x[1] + rect_x[2] + rect_x[3]) / 4 + jitter(span);
        y = (rect_y[0] + rect_y[1] + rect_y[2] + rect_y[3]) / 4 + jitter(span);
      end
      8: begin
        // sit right on an edge with a tiny circle to probe the strict compares
        t = $urandom_range(0, 16);
        x = rect_x[c] + (rect_x[nxt] - rect_x[c]) * t / 16 + jitter(2);
        y = rect_y[c] + (rect_y[nxt] - rect_y[c]) * t / 16 + jitter(2);
        rad = longint'($urandom_range(0, 4));
      end
      default: begin
        x = rect_x[c] + jitter(span);
        y = rect_y[c] + jitter(span);
        rad = 0;
      end
    endcase
    send_circle(x, y, rad);
  endtask

  task automatic run_queries(input int count);
    tx_quiet = ($urandom_range(0, 3) == 0);
    rx_quiet = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2 && $urandom_range(0, 1) == 1) wait_drain();
      random_circle();
    end
  endtask

  task automatic random_rect();
    longint mx, my, ux, uy;
    mx = jitter((1 << 22) - 1);
    my = jitter((1 << 22) - 1);
    ux = jitter(1 << $urandom_range(2, 21));
    uy = jitter(1 << $urandom_range(2, 21));
    load_quad(mx - ux + uy, my - uy - ux, mx + ux + uy, my + uy - ux,
              mx + ux - uy, my + uy + ux, mx - ux - uy, my - uy + ux);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // all corners at the origin after reset: every edge has zero length
    send_circle(0, 0, 0);
    send_circle(0, 0, 1);
    send_circle(5, -7, 0);
    send_circle(C_MIN, C_MAX, RADIUS_MAX);
    run_queries(60);

    load_quad(-1000, -500, 1000, -500, 1000, 500, -1000, 500);
    send_circle(0, 0, 0);              // zero radius, centre inside
    send_circle(1000, 0, 0);           // zero radius on the boundary counts as inside
    send_circle(1001, 0, 0);           // zero radius just outside
    send_circle(-1000, -500, 0);       // zero radius on a corner
    send_circle(1003, 0, 3);           // edge distance equals radius: no hit
    send_circle(1003, 0, 4);           // edge distance below radius
    send_circle(1003, 504, 5);         // corner distance equals radius: no hit
    send_circle(1003, 504, 6);         // corner strictly inside
    send_circle(0, 0, RADIUS_MAX);
    send_circle(C_MIN, C_MIN, RADIUS_MAX);
    send_circle(C_MAX, C_MAX, 0);
    send_circle(C_MIN, 0, RADIUS_MAX);
    send_circle(C_MAX, C_MIN, RADIUS_MAX);
    run_queries(150);

    // clockwise order: interior test fails, corners and edges still count
    load_quad(-1000, -500, -1000, 500, 1000, 500, 1000, -500);
    run_queries(150);
    load_quad(0, -3000, 3000, 0, 0, 3000, -3000, 0);
    run_queries(150);
    load_quad(C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX);
    run_queries(150);
    // two coincident corners
    load_quad(-200, -200, -200, -200, 400, 300, -200, 300);
    run_queries(120);
    load_quad(0, 0, 1000, 0, 2000, 0, 3000, 0);
    run_queries(100);
    for (int p = 0; p < 4; p++) begin
      random_rect();
      run_queries(150);
    end
    for (int p = 0; p < 3; p++) begin
      load_quad(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), rand_coord(), rand_coord());
      run_queries(100);
    end

    wait_drain();
    repeat (4 * cqo_pkg::NUM_STAGES) @(negedge clk);
    $display("Ran %0d circle queries over %0d corner settings, %0d beats checked.",
             items_sent, settings_used, results_seen);
    $display("Overlaps reported: %0d, clear: %0d, mismatches: %0d.",
             hits_seen, results_seen - hits_seen, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/cqo_pkg.sv
sv/circle_quad_overlap_test.sv
test/overlap_checker.sv
test/testbench.sv
